>>> rtl/core/azc_pkg.sv
// Shared widths and constants for the accelerometer zero calibration block.
`timescale 1ns / 1ps
`default_nettype none
package azc_pkg;

	// Field and state widths
	localparam int SAMPLE_W = 16;
	localparam int VPG_W    = 16;
	localparam int IGN_W    = 8;
	localparam int SUM_W    = 22;
	localparam int CNT_W    = 9;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	// Shared divider: dividend is |diff| << 8 or the running sum
	localparam int DIV_W     = 24;
	localparam int DVS_W     = 16;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// Defaults
	localparam int CAL_SAMPLES_DEF = 64;
	localparam logic [VPG_W-1:0] VPG_RESET = 16'd10000;
	localparam logic [IGN_W-1:0] IGN_RESET = 8'd10;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VOLTS_PER_G  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IGNORE_COUNT = 2'd1;

endpackage
`default_nettype wire

>>> rtl/core/azc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module azc_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [azc_pkg::DIV_W-1:0]     dividend,
	input  wire logic [azc_pkg::DVS_W-1:0]     divisor,
	output logic                               done,
	output logic [azc_pkg::DIV_W-1:0]          quotient
);

	logic                              busy_q;
	logic                              done_q;
	logic [azc_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [azc_pkg::DIV_W-1:0]         quo_q;
	logic [azc_pkg::DVS_W-1:0]         rem_q;
	logic [azc_pkg::DVS_W-1:0]         dvs_q;

	logic [azc_pkg::DVS_W:0]           trial;
	logic [azc_pkg::DVS_W+1:0]         diff;
	logic                              ge;

	// Shift in next dividend bit and try a subtract
	always_comb begin
		trial = {rem_q, quo_q[azc_pkg::DIV_W-1]};
		diff  = {1'b0, trial} - {2'b00, dvs_q};
		ge    = ~diff[azc_pkg::DVS_W+1];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == azc_pkg::DIV_CNT_W'(azc_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[azc_pkg::DIV_W-2:0], ge};
			rem_q <= ge ? diff[azc_pkg::DVS_W-1:0] : trial[azc_pkg::DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

>>> rtl/core/accel_zero_calibrate_deadzone.sv
// Accelerometer zero calibration: sequencer, calibration state and output stage.
//
// Usage: one sample enters on the input channel (in_valid / in_stall) and one
// result leaves on the output channel (out_valid / out_stall); a transfer
// happens when valid is high and stall is low. Configuration is a plain
// write port (cfg_we, cfg_index, cfg_data): index 0 is volts_per_g,
// index 1 is ignore_count, other indexes are ignored.
// Flow: a sample that is discarded, accumulated or falls in the dead band
// passes through the CALC and OUT states to the output register. The last
// calibration sample and every sample outside the dead band while
// volts_per_g is nonzero also go through the shared bit-serial divider
// (one quotient bit per cycle) in the DIV state between CALC and OUT.
// in_stall is high from the input transfer until the result is handed to
// the output register, so one sample is in work at a time.
// If the receiver stalls, the result waits in the output register; the next
// sample may still be taken and is held back only at its own hand-off.
// Reset: volts_per_g = 10000, ignore_count = 10, calibration restarts,
// band empty, zero level 0, output channel empty.
`timescale 1ns / 1ps
`default_nettype none
module accel_zero_calibrate_deadzone #(
	parameter int CAL_SAMPLES = azc_pkg::CAL_SAMPLES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [azc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [azc_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [azc_pkg::SAMPLE_W-1:0]      sample,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [azc_pkg::SAMPLE_W-1:0]    accel,
	output logic                                   calibrated,
	output logic                                   in_dead_band,
	output logic                                   saturated
);

	localparam int SW  = azc_pkg::SAMPLE_W;
	localparam int LW  = azc_pkg::CNT_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CALC = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t                         state_q;
	logic [azc_pkg::VPG_W-1:0]      vpg_q;
	logic [azc_pkg::IGN_W-1:0]      ign_q;
	logic [azc_pkg::CNT_W-1:0]      cnt_q;
	logic [azc_pkg::SUM_W-1:0]      sum_q;
	logic [SW-1:0]                  low_q;
	logic [SW-1:0]                  high_q;
	logic [SW-1:0]                  zero_q;
	logic                           done_q;
	logic [SW-1:0]                  s_q;
	logic                           neg_q;
	logic                           zdiv_q;

	// Pending result
	logic [SW-1:0]                  res_accel_q;
	logic                           res_cal_q;
	logic                           res_dead_q;
	logic                           res_sat_q;

	// Output register
	logic                           out_valid_q;
	logic [SW-1:0]                  out_accel_q;
	logic                           out_cal_q;
	logic                           out_dead_q;
	logic                           out_sat_q;

	// Combinational helpers
	logic                           in_xfer;
	logic                           out_free;
	logic                           accum;
	logic                           last_cal;
	logic [LW-1:0]                  limit;
	logic [LW-1:0]                  cnt_p1;
	logic [azc_pkg::SUM_W:0]        sum_ext;
	logic [azc_pkg::SUM_W-1:0]      sum_next;
	logic                           dead;
	logic                           neg;
	logic [SW-1:0]                  mag;
	logic                           div_start;
	logic [azc_pkg::DIV_W-1:0]      div_dividend;
	logic [azc_pkg::DVS_W-1:0]      div_divisor;
	logic                           div_done;
	logic [azc_pkg::DIV_W-1:0]      div_quo;

	assign in_xfer  = (state_q == ST_IDLE) && in_valid;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Calibration window and saturating sum
	always_comb begin
		limit    = LW'(ign_q) + LW'(CAL_SAMPLES);
		cnt_p1   = LW'(cnt_q) + 1'b1;
		accum    = cnt_q >= azc_pkg::CNT_W'(ign_q);
		last_cal = accum && (cnt_p1 >= limit);
		sum_ext  = (azc_pkg::SUM_W+1)'(sum_q) + (azc_pkg::SUM_W+1)'(s_q);
		sum_next = sum_ext[azc_pkg::SUM_W] ? '1 : sum_ext[azc_pkg::SUM_W-1:0];
	end

	// Dead band test and magnitude of the offset-corrected sample
	always_comb begin
		dead = (s_q > low_q) && (s_q < high_q);
		neg  = s_q < zero_q;
		mag  = neg ? (zero_q - s_q) : (s_q - zero_q);
	end

	// Divider request: zero level or scaled sample
	always_comb begin
		div_start    = 1'b0;
		div_dividend = {mag, 8'h00};
		div_divisor  = vpg_q;
		if (state_q == ST_CALC) begin
			if (!done_q) begin
				div_start    = last_cal;
				div_dividend = azc_pkg::DIV_W'(sum_next);
				div_divisor  = azc_pkg::DVS_W'(CAL_SAMPLES);
			end else begin
				div_start = !dead && (vpg_q != '0);
			end
		end
	end

	azc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpg_q <= azc_pkg::VPG_RESET;
			ign_q <= azc_pkg::IGN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				azc_pkg::REG_VOLTS_PER_G:  vpg_q <= cfg_data[azc_pkg::VPG_W-1:0];
				azc_pkg::REG_IGNORE_COUNT: ign_q <= cfg_data[azc_pkg::IGN_W-1:0];
				default: ;
			endcase
		end
	end

	// Sample capture
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			s_q <= sample;
		end
	end

	// Sequencer and calibration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sum_q       <= '0;
			low_q       <= '1;
			high_q      <= '0;
			zero_q      <= '0;
			done_q      <= 1'b0;
			neg_q       <= 1'b0;
			zdiv_q      <= 1'b0;
			res_accel_q <= '0;
			res_cal_q   <= 1'b0;
			res_dead_q  <= 1'b0;
			res_sat_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					res_accel_q <= '0;
					res_cal_q   <= done_q;
					res_dead_q  <= 1'b0;
					res_sat_q   <= 1'b0;
					neg_q       <= neg;
					zdiv_q      <= !done_q;
					if (!done_q) begin
						// Discard or accumulate
						if (accum) begin
							sum_q <= sum_next;
							if (s_q < low_q) begin
								low_q <= s_q;
							end
							if (s_q > high_q) begin
								high_q <= s_q;
							end
						end
						if (last_cal) begin
							state_q <= ST_DIV;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= ST_OUT;
						end
					end else if (dead) begin
						res_dead_q <= 1'b1;
						state_q    <= ST_OUT;
					end else if (vpg_q == '0) begin
						// No sensitivity: any offset clips
						if (mag != '0) begin
							res_sat_q   <= 1'b1;
							res_accel_q <= neg ? {1'b1, {(SW-1){1'b0}}}
							                   : {1'b0, {(SW-1){1'b1}}};
						end
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (zdiv_q) begin
							// Fix the zero level
							zero_q <= (div_quo[azc_pkg::DIV_W-1:SW] != '0) ? '1
							                                                : div_quo[SW-1:0];
							done_q <= 1'b1;
						end else if (!neg_q) begin
							if (div_quo[azc_pkg::DIV_W-1:SW-1] != '0) begin
								res_sat_q   <= 1'b1;
								res_accel_q <= {1'b0, {(SW-1){1'b1}}};
							end else begin
								res_accel_q <= div_quo[SW-1:0];
							end
						end else begin
							if ((div_quo[azc_pkg::DIV_W-1:SW] != '0) ||
							    (div_quo[SW-1] && (div_quo[SW-2:0] != '0))) begin
								res_sat_q   <= 1'b1;
								res_accel_q <= {1'b1, {(SW-1){1'b0}}};
							end else begin
								res_accel_q <= -div_quo[SW-1:0];
							end
						end
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			out_accel_q <= res_accel_q;
			out_cal_q   <= res_cal_q;
			out_dead_q  <= res_dead_q;
			out_sat_q   <= res_sat_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign accel        = out_accel_q;
	assign calibrated   = out_cal_q;
	assign in_dead_band = out_dead_q;
	assign saturated    = out_sat_q;

endmodule
`default_nettype wire
